// ===== hdl/knn_pkg.sv =====
package knn_pkg;

    localparam int ELEM_W = 16;
    localparam int ID_W   = 64;
    localparam int DIST_W = 19;
    localparam int SUM_W  = 38;
    localparam int CNT_W  = 6;
    localparam int STAT_W = 3;
    localparam int CFG_W  = 6;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STAT_W-1:0] ST_LEN   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOID  = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd4;

    localparam logic REG_NEIGHBOR_COUNT = 1'b0;
    localparam logic REG_VECTOR_LENGTH  = 1'b1;

    // highest power of four below 2**SUM_W
    localparam logic [SUM_W-1:0] SQRT_BIT0 = 38'h10_0000_0000;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [ELEM_W-1:0] element_value;
        logic signed [ID_W-1:0]   record_id;
        logic                     last_element;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [ID_W-1:0]   result_id;
        logic [DIST_W-1:0]        distance;
        logic signed [ELEM_W-1:0] fetched_value;
        logic                     last_result;
    } t_out_item;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [ELEM_W-1:0] element_value;
        logic [CNT_W-1:0]         pos;
        logic signed [ID_W-1:0]   record_id;
        logic                     last_element;
    } t_cmd;

endpackage

// ===== hdl/knn_front.sv =====
module knn_front
    import knn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic [CNT_W-1:0] r_elem_cnt;
    logic             w_xfer;

    assign o_in_ready = !i_q_full;
    assign w_xfer     = i_in_valid && o_in_ready;
    assign o_push     = w_xfer && (i_in_item.opcode != OP_NONE);

    always_comb begin
        o_cmd.opcode        = i_in_item.opcode;
        o_cmd.element_value = i_in_item.element_value;
        o_cmd.pos           = r_elem_cnt;
        o_cmd.record_id     = i_in_item.record_id;
        o_cmd.last_element  = i_in_item.last_element;
    end

    // element position shared by add and query streams, saturating
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_cnt <= '0;
        end else if (w_xfer && (i_in_item.opcode == OP_ADD || i_in_item.opcode == OP_QUERY)) begin
            if (i_in_item.last_element) begin
                r_elem_cnt <= '0;
            end else if (r_elem_cnt != '1) begin
                r_elem_cnt <= r_elem_cnt + CNT_W'(1);
            end
        end
    end

endmodule

// ===== hdl/knn_cmdq.sv =====
module knn_cmdq
    import knn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int DEPTH = 4;
    localparam int PW    = 2;

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [PW:0]     r_cnt;
    logic            w_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

endmodule

// ===== hdl/knn_back.sv =====
module knn_back
    import knn_pkg::*;
#(
    parameter int MAX_ITEMS  = 256,
    parameter int MAX_LENGTH = 32,
    parameter int MAX_K      = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    localparam int SW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int LW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int KW = $clog2(MAX_K + 1);
    localparam int JW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int AW = SW + LW;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EMIT1   = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_SQRT    = 4'd3;
    localparam logic [3:0] S_INS     = 4'd4;
    localparam logic [3:0] S_QOUT_RD = 4'd5;
    localparam logic [3:0] S_QOUT    = 4'd6;
    localparam logic [3:0] S_FSRCH   = 4'd7;
    localparam logic [3:0] S_FCMP    = 4'd8;
    localparam logic [3:0] S_FOUT_RD = 4'd9;
    localparam logic [3:0] S_FOUT    = 4'd10;

    logic [3:0]        r_state;
    logic [4:0]        r_ncount;
    logic [CNT_W-1:0]  r_vlen;
    logic [CW-1:0]     r_count;

    logic [ELEM_W-1:0] r_vec_mem [MAX_ITEMS * (2 ** LW)];
    logic [ID_W-1:0]   r_id_mem  [MAX_ITEMS];
    logic [ELEM_W-1:0] r_qbuf    [2 ** LW];
    logic [ELEM_W-1:0] r_vec_rd;
    logic [ELEM_W-1:0] r_q_rd;
    logic [ID_W-1:0]   r_id_rd;

    logic              w_vec_we;
    logic [AW-1:0]     w_vec_waddr;
    logic              w_vec_re;
    logic [AW-1:0]     w_vec_raddr;
    logic              w_q_we;
    logic              w_id_we;
    logic              w_id_re;
    logic [SW-1:0]     w_id_raddr;

    logic [CW-1:0]     r_slot;
    logic [CNT_W-1:0]  r_idx;
    logic [ID_W-1:0]   r_rid;
    logic [STAT_W-1:0] r_pend_status;
    logic [ID_W-1:0]   r_pend_id;

    logic                r_p1_v, r_p1_last;
    logic                r_p2_v, r_p2_last;
    logic                r_p3_v, r_p3_last;
    logic signed [16:0]  r_diff;
    logic signed [33:0]  w_prod;
    logic [33:0]         r_sq;
    logic [SUM_W-1:0]    r_acc;
    logic [SUM_W-1:0]    w_sum;

    logic [SUM_W-1:0]  r_rad;
    logic [SUM_W-1:0]  r_res;
    logic [SUM_W-1:0]  r_bit;
    logic [SUM_W-1:0]  w_trial;
    logic              w_take;

    logic [DIST_W-1:0] r_best_d [MAX_K];
    logic [SW-1:0]     r_best_s [MAX_K];
    logic [DIST_W-1:0] n_best_d [MAX_K];
    logic [SW-1:0]     n_best_s [MAX_K];
    logic [MAX_K-1:0]  w_le;
    logic [KW-1:0]     r_filled;
    logic [KW-1:0]     r_j;
    logic [KW-1:0]     w_k;
    logic [DIST_W-1:0] w_d;
    logic              w_ins_ok;

    logic              r_out_valid;
    t_out_item         r_out;
    logic              w_out_free;
    logic              w_out_load;

    logic              w_full;
    logic              w_pos_ok;
    logic              w_len_ok;
    logic              w_vlen_ok;
    logic              w_issue;
    logic              w_take_cmd;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_out_load  = w_out_free && ((r_state == S_EMIT1) || (r_state == S_QOUT)
                                        || (r_state == S_FOUT));
    assign w_take_cmd  = (r_state == S_IDLE) && i_cmd_valid;
    assign o_cmd_pop   = w_take_cmd;

    assign w_full    = (r_count == CW'(MAX_ITEMS));
    assign w_pos_ok  = (int'(i_cmd.pos) < MAX_LENGTH);
    assign w_vlen_ok = (r_vlen != '0) && (int'(r_vlen) <= MAX_LENGTH);
    assign w_len_ok  = (({1'b0, i_cmd.pos} + 7'd1) == {1'b0, r_vlen})
                       && (int'(r_vlen) <= MAX_LENGTH);

    always_comb begin
        if (r_ncount == '0) begin
            w_k = KW'(1);
        end else if (int'(r_ncount) > MAX_K) begin
            w_k = KW'(MAX_K);
        end else begin
            w_k = KW'(r_ncount);
        end
    end

    // memory ports
    assign w_vec_we    = w_take_cmd && (i_cmd.opcode == OP_ADD) && !w_full && w_pos_ok;
    assign w_vec_waddr = {r_count[SW-1:0], i_cmd.pos[LW-1:0]};
    assign w_q_we      = w_take_cmd && (i_cmd.opcode == OP_QUERY) && w_pos_ok;
    assign w_id_we     = w_take_cmd && (i_cmd.opcode == OP_ADD) && i_cmd.last_element
                         && !w_full && w_len_ok;
    assign w_issue     = (r_state == S_SCAN) && (r_idx != r_vlen);
    assign w_vec_re    = w_issue || (r_state == S_FOUT_RD);
    assign w_vec_raddr = {r_slot[SW-1:0], r_idx[LW-1:0]};
    assign w_id_re     = ((r_state == S_FSRCH) && (r_slot != r_count)) || (r_state == S_QOUT_RD);
    assign w_id_raddr  = (r_state == S_QOUT_RD) ? r_best_s[r_j[JW-1:0]] : r_slot[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_vec_we) begin
            r_vec_mem[w_vec_waddr] <= i_cmd.element_value;
        end
        if (w_vec_re) begin
            r_vec_rd <= r_vec_mem[w_vec_raddr];
        end
        if (w_q_we) begin
            r_qbuf[i_cmd.pos[LW-1:0]] <= i_cmd.element_value;
        end
        if (w_issue) begin
            r_q_rd <= r_qbuf[r_idx[LW-1:0]];
        end
        if (w_id_we) begin
            r_id_mem[r_count[SW-1:0]] <= i_cmd.record_id;
        end
        if (w_id_re) begin
            r_id_rd <= r_id_mem[w_id_raddr];
        end
    end

    // distance pipeline: difference, square, accumulate
    assign w_prod = r_diff * r_diff;
    assign w_sum  = r_acc + SUM_W'(r_sq);

    always_ff @(posedge i_clk) begin
        r_diff <= $signed({r_q_rd[ELEM_W-1], r_q_rd}) - $signed({r_vec_rd[ELEM_W-1], r_vec_rd});
        r_sq   <= w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else begin
            r_p1_v <= w_issue;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
        end
        r_p1_last <= ({1'b0, r_idx} + 7'd1) == {1'b0, r_vlen};
        r_p2_last <= r_p1_last;
        r_p3_last <= r_p2_last;
    end

    // one result bit per cycle
    assign w_trial = r_res + r_bit;
    assign w_take  = (r_rad >= w_trial);

    // sorted insertion, ties keep the earlier slot ahead
    assign w_d      = r_res[DIST_W-1:0];
    assign w_ins_ok = (r_filled < w_k) || (w_d < r_best_d[JW'(w_k - KW'(1))]);

    always_comb begin
        for (int j = 0; j < MAX_K; j++) begin
            w_le[j] = (KW'(j) < r_filled) && (r_best_d[j] <= w_d);
        end
        for (int j = 0; j < MAX_K; j++) begin
            if (w_le[j]) begin
                n_best_d[j] = r_best_d[j];
                n_best_s[j] = r_best_s[j];
            end else if (j == 0) begin
                n_best_d[j] = w_d;
                n_best_s[j] = r_slot[SW-1:0];
            end else if (w_le[j-1]) begin
                n_best_d[j] = w_d;
                n_best_s[j] = r_slot[SW-1:0];
            end else begin
                n_best_d[j] = r_best_d[j-1];
                n_best_s[j] = r_best_s[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_INS) && w_ins_ok) begin
            for (int j = 0; j < MAX_K; j++) begin
                r_best_d[j] <= n_best_d[j];
                r_best_s[j] <= n_best_s[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ncount    <= 5'd1;
            r_vlen      <= 6'd32;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_filled    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_NEIGHBOR_COUNT) begin
                    r_ncount <= i_cfg_data[4:0];
                end else begin
                    r_vlen <= i_cfg_data;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_rid <= i_cmd.record_id;
                        unique case (i_cmd.opcode)
                            OP_ADD: begin
                                if (i_cmd.last_element) begin
                                    r_pend_id <= i_cmd.record_id;
                                    r_state   <= S_EMIT1;
                                    if (w_full) begin
                                        r_pend_status <= ST_FULL;
                                    end else if (!w_len_ok) begin
                                        r_pend_status <= ST_LEN;
                                    end else begin
                                        r_pend_status <= ST_OK;
                                        r_count       <= r_count + CW'(1);
                                    end
                                end
                            end
                            OP_QUERY: begin
                                if (i_cmd.last_element) begin
                                    r_pend_id <= '0;
                                    if (r_count == '0) begin
                                        r_pend_status <= ST_EMPTY;
                                        r_state       <= S_EMIT1;
                                    end else if (!w_len_ok) begin
                                        r_pend_status <= ST_LEN;
                                        r_state       <= S_EMIT1;
                                    end else begin
                                        r_slot   <= '0;
                                        r_idx    <= '0;
                                        r_acc    <= '0;
                                        r_filled <= '0;
                                        r_state  <= S_SCAN;
                                    end
                                end
                            end
                            OP_FETCH: begin
                                r_slot  <= '0;
                                r_state <= S_FSRCH;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_EMIT1: begin
                    if (w_out_free) begin
                        r_out.status        <= r_pend_status;
                        r_out.result_id     <= r_pend_id;
                        r_out.distance      <= '0;
                        r_out.fetched_value <= '0;
                        r_out.last_result   <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (w_issue) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (r_p3_v) begin
                        if (r_p3_last) begin
                            r_rad   <= w_sum;
                            r_res   <= '0;
                            r_bit   <= SQRT_BIT0;
                            r_acc   <= '0;
                            r_state <= S_SQRT;
                        end else begin
                            r_acc <= w_sum;
                        end
                    end
                end
                S_SQRT: begin
                    if (w_take) begin
                        r_rad <= r_rad - w_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == SUM_W'(1)) begin
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    if (w_ins_ok && (r_filled < w_k)) begin
                        r_filled <= r_filled + KW'(1);
                    end
                    if ((r_slot + CW'(1)) == r_count) begin
                        r_j     <= '0;
                        r_state <= S_QOUT_RD;
                    end else begin
                        r_slot  <= r_slot + CW'(1);
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_QOUT_RD: begin
                    r_state <= S_QOUT;
                end
                S_QOUT: begin
                    if (w_out_free) begin
                        r_out.status        <= ST_OK;
                        r_out.result_id     <= r_id_rd;
                        r_out.distance      <= r_best_d[r_j[JW-1:0]];
                        r_out.fetched_value <= '0;
                        r_out.last_result   <= (r_j + KW'(1)) == r_filled;
                        if ((r_j + KW'(1)) == r_filled) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + KW'(1);
                            r_state <= S_QOUT_RD;
                        end
                    end
                end
                S_FSRCH: begin
                    if (r_slot == r_count) begin
                        r_pend_status <= ST_NOID;
                        r_pend_id     <= r_rid;
                        r_state       <= S_EMIT1;
                    end else begin
                        r_state <= S_FCMP;
                    end
                end
                S_FCMP: begin
                    if (r_id_rd == r_rid) begin
                        if (!w_vlen_ok) begin
                            r_pend_status <= ST_LEN;
                            r_pend_id     <= r_rid;
                            r_state       <= S_EMIT1;
                        end else begin
                            r_idx   <= '0;
                            r_state <= S_FOUT_RD;
                        end
                    end else begin
                        r_slot  <= r_slot + CW'(1);
                        r_state <= S_FSRCH;
                    end
                end
                S_FOUT_RD: begin
                    r_state <= S_FOUT;
                end
                S_FOUT: begin
                    if (w_out_free) begin
                        r_out.status        <= ST_OK;
                        r_out.result_id     <= r_rid;
                        r_out.distance      <= '0;
                        r_out.fetched_value <= r_vec_rd;
                        r_out.last_result   <= (r_idx + CNT_W'(1)) == r_vlen;
                        if ((r_idx + CNT_W'(1)) == r_vlen) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= S_FOUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/knn_vector_store.sv =====
// add and query elements: one per cycle while the command queue is not full; a finished
//   add's result goes out via the queue, the EMIT1 state and the output register
// query: the single distance pipeline and one-bit-per-cycle square root unit score each
//   stored record in turn; fetch: id search slot by slot, then one element at a time
// a 4-entry command queue lets input transfers continue while the back end is busy
// synchronous active-low reset empties the store; memories are not cleared
module knn_vector_store
    import knn_pkg::*;
#(
    parameter int MAX_ITEMS  = 256,
    parameter int MAX_LENGTH = 32,
    parameter int MAX_K      = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_full;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_pop;

    knn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    knn_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    knn_back #(
        .MAX_ITEMS  (MAX_ITEMS),
        .MAX_LENGTH (MAX_LENGTH),
        .MAX_K      (MAX_K)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== hdl/knn_checker.sv =====
module knn_checker
    import knn_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input t_out_item        o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != ST_OK) |-> o_out_item.last_result)
        else $error("error result not closing its run");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != ST_OK)
        |-> (o_out_item.distance == '0) && (o_out_item.fetched_value == '0))
        else $error("error result carries data");

endmodule

bind knn_vector_store knn_checker u_knn_checker (.*);

// ===== tb/knn_vector_store_test.sv =====
`timescale 1ns / 1ps

module knn_vector_store_test;
    import knn_pkg::*;

    localparam int SLOTS    = 256;
    localparam int VEC_MAX  = 32;
    localparam int K_MAX    = 16;
    localparam int SETTLE   = 200;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_idx = REG_NEIGHBOR_COUNT;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_in_item         i_in_item = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_item        o_out_item;

    knn_vector_store uut (.*);

    always #1 i_clk = ~i_clk;

    // shadow of the store
    logic signed [ELEM_W-1:0] vec_mem [SLOTS][VEC_MAX];
    logic signed [ID_W-1:0]   id_mem [SLOTS];
    logic signed [ELEM_W-1:0] query_vec [VEC_MAX];
    int                       n_stored = 0;
    int                       elem_pos = 0;
    int                       k_reg = 1;
    int                       len_reg = 32;

    t_in_item  pending_q [$];
    t_out_item expected_q [$];
    int        n_queued = 0;
    int        n_accepted = 0;
    int        n_results = 0;
    int        n_queries = 0;
    int        n_errors = 0;
    bit        burst = 1'b0;
    int        in_gap = 0;
    int        out_stall = 0;

    logic signed [ID_W-1:0] id_pool [8];

    function automatic int floor_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned t;
        for (int b = 19; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return int'(r);
    endfunction

    function automatic void expect_result(logic [STAT_W-1:0] st, logic [ID_W-1:0] id,
                                          int dist_val, logic [ELEM_W-1:0] val, bit last);
        t_out_item r;
        r.status = st;
        r.result_id = id;
        r.distance = DIST_W'(dist_val);
        r.fetched_value = val;
        r.last_result = last;
        expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic void predict_knn();
        int  slot_d;
        int  best_d [K_MAX];
        int  best_s [K_MAX];
        int  k;
        int  filled = 0;
        int  j;
        longint diff;
        longint unsigned acc;
        k = (k_reg == 0) ? 1 : (k_reg > K_MAX ? K_MAX : k_reg);
        for (int s = 0; s < n_stored; s++) begin
            acc = 0;
            for (int i = 0; i < len_reg; i++) begin
                diff = longint'(query_vec[i]) - longint'(vec_mem[s][i]);
                acc += longint'(diff * diff);
            end
            slot_d = floor_sqrt(acc);
            if (filled == k && slot_d >= best_d[k-1]) continue;
            if (filled < k) begin
                j = filled;
                filled++;
            end else begin
                j = k - 1;
            end
            while (j > 0 && best_d[j-1] > slot_d) begin
                best_d[j] = best_d[j-1];
                best_s[j] = best_s[j-1];
                j--;
            end
            best_d[j] = slot_d;
            best_s[j] = s;
        end
        for (int i = 0; i < filled; i++)
            expect_result(ST_OK, id_mem[best_s[i]], best_d[i], '0, i + 1 == filled);
    endfunction

    function automatic void predict_transfer(t_in_item it);
        int  pos;
        bit  len_ok;
        bit  found = 1'b0;
        pos = elem_pos;
        case (it.opcode)
            OP_NONE: return;
            OP_FETCH: begin
                for (int s = 0; s < n_stored && !found; s++) begin
                    if (id_mem[s] == it.record_id) begin
                        found = 1'b1;
                        if (len_reg == 0 || len_reg > VEC_MAX)
                            expect_result(ST_LEN, it.record_id, 0, '0, 1'b1);
                        else
                            for (int i = 0; i < len_reg; i++)
                                expect_result(ST_OK, it.record_id, 0, vec_mem[s][i],
                                              i + 1 == len_reg);
                    end
                end
                if (!found) expect_result(ST_NOID, it.record_id, 0, '0, 1'b1);
                return;
            end
            OP_ADD: if (n_stored < SLOTS && pos < VEC_MAX) vec_mem[n_stored][pos] = it.element_value;
            default: if (pos < VEC_MAX) query_vec[pos] = it.element_value;
        endcase
        if (!it.last_element) begin
            if (elem_pos < 63) elem_pos++;
            return;
        end
        elem_pos = 0;
        len_ok = (pos + 1 == len_reg) && (len_reg <= VEC_MAX);
        if (it.opcode == OP_ADD) begin
            if (n_stored >= SLOTS) expect_result(ST_FULL, it.record_id, 0, '0, 1'b1);
            else if (!len_ok) expect_result(ST_LEN, it.record_id, 0, '0, 1'b1);
            else begin
                id_mem[n_stored] = it.record_id;
                n_stored++;
                expect_result(ST_OK, it.record_id, 0, '0, 1'b1);
            end
        end else begin
            n_queries++;
            if (n_stored == 0) expect_result(ST_EMPTY, '0, 0, '0, 1'b1);
            else if (!len_ok) expect_result(ST_LEN, '0, 0, '0, 1'b1);
            else predict_knn();
        end
    endfunction

    // driver: one item per transfer, random gap after each unless in burst mode
    always @(posedge i_clk) begin
        bit fire;
        fire = i_in_valid && o_in_ready;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (fire) begin
                predict_transfer(i_in_item);
                n_accepted++;
            end
            if (!i_in_valid || fire) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    i_in_item <= pending_q.pop_front();
                    i_in_valid <= 1'b1;
                    in_gap = burst ? 0 : $urandom_range(0, 5);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (expected_q.size() == 0) begin
                    $error("unexpected result %p", o_out_item);
                    n_errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (o_out_item.status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, o_out_item.status);
                        n_errors++;
                    end
                    if (o_out_item.result_id !== e.result_id) begin
                        $error("result_id: expected %0d, got %0d", e.result_id,
                               o_out_item.result_id);
                        n_errors++;
                    end
                    if (o_out_item.distance !== e.distance) begin
                        $error("distance: expected %0d, got %0d", e.distance,
                               o_out_item.distance);
                        n_errors++;
                    end
                    if (o_out_item.fetched_value !== e.fetched_value) begin
                        $error("fetched_value: expected %0d, got %0d", e.fetched_value,
                               o_out_item.fetched_value);
                        n_errors++;
                    end
                    if (o_out_item.last_result !== e.last_result) begin
                        $error("last_result: expected %0d, got %0d", e.last_result,
                               o_out_item.last_result);
                        n_errors++;
                    end
                end
                out_stall = burst ? 0 : $urandom_range(0, 5);
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic void queue_item(logic [1:0] op, logic [ELEM_W-1:0] val,
                                       logic [ID_W-1:0] id, bit last);
        t_in_item it;
        it.opcode = op;
        it.element_value = val;
        it.record_id = id;
        it.last_element = last;
        pending_q.insert(pending_q.size(), it);
        n_queued++;
    endfunction

    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        return {$urandom, $urandom};
    endfunction

    // stream of len elements; fixed set gives constant val, otherwise random and fetch may cut in
    function automatic void queue_vector(logic [1:0] op, int len, logic [ID_W-1:0] id,
                                         bit fixed, logic [ELEM_W-1:0] val);
        for (int i = 0; i < len; i++) begin
            if (!fixed && $urandom_range(0, 15) == 0)
                queue_item(OP_FETCH, rand_elem(), id_pool[$urandom_range(0, 7)], 1'b0);
            queue_item(op, fixed ? val : rand_elem(), i + 1 == len ? id : rand_id(),
                       i + 1 == len);
        end
    endfunction

    task automatic wait_idle();
        while (n_accepted != n_queued || expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_NEIGHBOR_COUNT) k_reg = value & 31;
        else len_reg = value & 63;
        @(posedge i_clk);
    endtask

    task automatic random_phase(int n_items, int vlen);
        int r;
        int len;
        while (n_queued < n_items) begin
            r = $urandom_range(0, 9);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, vlen + 2) : vlen;
            if (r < 4)
                queue_vector(OP_ADD, len, $urandom_range(0, 3) == 0 ? rand_id()
                             : id_pool[$urandom_range(0, 7)], 1'b0, '0);
            else if (r < 7)
                queue_vector(OP_QUERY, len, rand_id(), 1'b0, '0);
            else if (r < 9)
                queue_item(OP_FETCH, rand_elem(), $urandom_range(0, 2) == 0 ? rand_id()
                           : id_pool[$urandom_range(0, 7)], 1'($urandom_range(0, 1)));
            else
                queue_item(OP_NONE, rand_elem(), rand_id(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            id_mem[s] = '0;
            for (int i = 0; i < VEC_MAX; i++) vec_mem[s][i] = '0;
        end
        for (int i = 0; i < VEC_MAX; i++) query_vec[i] = '0;
        for (int i = 0; i < 8; i++) id_pool[i] = rand_id();
        id_pool[0] = 64'sh7fff_ffff_ffff_ffff;
        id_pool[1] = 64'sh8000_0000_0000_0000;
        id_pool[2] = '0;
        id_pool[3] = '1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, defaults
        queue_item(OP_QUERY, 16'h1234, rand_id(), 1'b1);
        queue_item(OP_FETCH, '0, id_pool[0], 1'b1);
        queue_item(OP_NONE, 16'h7fff, rand_id(), 1'b1);
        queue_item(OP_ADD, 16'h8000, id_pool[1], 1'b1);
        write_reg(REG_VECTOR_LENGTH, 0);
        write_reg(REG_NEIGHBOR_COUNT, 0);
        queue_item(OP_ADD, 16'h0001, id_pool[2], 1'b1);
        queue_item(OP_QUERY, 16'h0001, rand_id(), 1'b1);
        write_reg(REG_VECTOR_LENGTH, 63);
        queue_item(OP_ADD, 16'hffff, id_pool[3], 1'b1);

        // full-length vectors at the field extremes
        write_reg(REG_VECTOR_LENGTH, 32);
        write_reg(REG_NEIGHBOR_COUNT, 31);
        burst = 1'b1;
        queue_vector(OP_ADD, 32, id_pool[0], 1'b1, 16'h8000);
        queue_vector(OP_QUERY, 32, rand_id(), 1'b1, 16'h7fff);
        queue_item(OP_FETCH, '0, id_pool[0], 1'b0);
        wait_idle();
        burst = 1'b0;

        // random traffic on short vectors, several neighbor counts
        write_reg(REG_VECTOR_LENGTH, 4);
        write_reg(REG_NEIGHBOR_COUNT, 3);
        random_phase(n_queued + 25, 4);
        write_reg(REG_NEIGHBOR_COUNT, 16);
        burst = 1'b1;
        random_phase(n_queued + 20, 4);
        wait_idle();
        burst = 1'b0;
        write_reg(REG_NEIGHBOR_COUNT, 1);
        random_phase(n_queued + 20, 4);

        // length register out of range while records are present
        write_reg(REG_VECTOR_LENGTH, 0);
        queue_item(OP_FETCH, '0, id_pool[0], 1'b1);
        queue_vector(OP_QUERY, 2, rand_id(), 1'b0, '0);

        // single-element vectors, counter saturation on a long stream
        write_reg(REG_VECTOR_LENGTH, 1);
        write_reg(REG_NEIGHBOR_COUNT, 16);
        queue_vector(OP_QUERY, 65, rand_id(), 1'b0, '0);
        queue_vector(OP_QUERY, 1, rand_id(), 1'b0, '0);
        wait_idle();
        queue_vector(OP_QUERY, 1, rand_id(), 1'b0, '0);
        queue_item(OP_FETCH, '0, id_pool[$urandom_range(0, 7)], 1'b1);
        queue_vector(OP_QUERY, 1, rand_id(), 1'b1, 16'h8000);
        wait_idle();

        $display("tb: %0d input transfers, %0d result transfers, %0d query vectors",
                 n_accepted, n_results, n_queries);
        $display("tb: store ended with %0d records", n_stored);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
